FILE: sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared constants and types for the checksummed command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 49;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT = 8'hF1;

    localparam logic [7:0] FUNC_CALIB    = 8'h01;
    localparam logic [7:0] FUNC_PID      = 8'h02;
    localparam logic [7:0] FUNC_SETPOINT = 8'h10;
    localparam logic [7:0] FUNC_ACK_LAST = 8'h15;

    localparam logic signed [15:0] SETPOINT_MAX = 16'sd500;

    // Frame snapshot handed from the parser to the decoder at the checksum byte
    typedef struct packed {
        logic [7:0] func;
        logic [7:0] byte_hi;
        logic [7:0] byte_lo;
        logic [7:0] sum;
        logic [7:0] chk;
    } frame_t;

    typedef struct packed {
        logic              frame_ok;
        logic [7:0]        function_code;
        logic              calibrate_request;
        logic              pid_report_request;
        logic              setpoint_write;
        logic signed [15:0] setpoint_value;
        logic              ack_request;
        logic [7:0]        ack_checksum;
        logic              save_timer_clear;
    } result_t;

endpackage

FILE: sv/cfp_parser.sv
// ----------------------------------------------------------------------------
// cfp_parser
// Frame hunt state machine with running checksum and captured payload bytes.
// ----------------------------------------------------------------------------
module cfp_parser
    import cfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       done,
    output frame_t     frame
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_HDR2   = 3'd1;
    localparam logic [2:0] PH_FUNC   = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;

    localparam logic [LEN_W-1:0] ONE_LEFT = LEN_W'(1);

    logic [2:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [1:0]       seen_reg, seen_next;     // saturates at two
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       b4_reg, b4_next;
    logic [7:0]       b5_reg, b5_next;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        func_next  = func_reg;
        b4_next    = b4_reg;
        b5_next    = b5_reg;
        done       = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        phase_next = PH_HDR2;
                        sum_next   = rx_byte;
                    end
                end
                PH_HDR2:
                begin
                    phase_next = (rx_byte == HDR_SECOND) ? PH_FUNC : PH_HUNT;
                    sum_next   = sum_reg + rx_byte;
                end
                PH_FUNC:
                begin
                    phase_next = (rx_byte < FUNC_LIMIT) ? PH_LEN : PH_HUNT;
                    func_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                end
                PH_LEN:
                begin
                    phase_next = (rx_byte <= 8'(MAX_PAYLOAD)) ? PH_DATA : PH_HUNT;
                    left_next  = rx_byte[LEN_W-1:0];
                    seen_next  = 2'd0;
                    sum_next   = sum_reg + rx_byte;
                end
                PH_DATA:
                begin
                    // zero length lands here with nothing to read: byte dropped
                    if (left_reg == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        if (seen_reg == 2'd0)
                        begin
                            b4_next = rx_byte;
                        end
                        if (seen_reg == 2'd1)
                        begin
                            b5_next = rx_byte;
                        end
                        if (seen_reg != 2'd2)
                        begin
                            seen_next = seen_reg + 2'd1;
                        end
                        left_next = left_reg - ONE_LEFT;
                        sum_next  = sum_reg + rx_byte;
                        if (left_reg == ONE_LEFT)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                end
                PH_CHECK:
                begin
                    done       = 1'b1;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Length one: the low setpoint byte is the checksum byte itself
    assign frame.func    = func_reg;
    assign frame.byte_hi = b4_reg;
    assign frame.byte_lo = (seen_reg == 2'd2) ? b5_reg : rx_byte;
    assign frame.sum     = sum_reg;
    assign frame.chk     = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            seen_reg  <= 2'd0;
            sum_reg   <= 8'd0;
            func_reg  <= 8'd0;
            b4_reg    <= 8'd0;
            b5_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            func_reg  <= func_next;
            b4_reg    <= b4_next;
            b5_reg    <= b5_next;
        end
    end

endmodule

FILE: sv/cfp_decoder.sv
// ----------------------------------------------------------------------------
// cfp_decoder
// Checksum compare and command decode of a completed frame.
// ----------------------------------------------------------------------------
module cfp_decoder
    import cfp_pkg::*;
(
    input  frame_t  frame,
    output result_t result
);

    logic               ok;
    logic signed [15:0] raw;

    assign ok  = (frame.chk == frame.sum);
    assign raw = $signed({frame.byte_hi, frame.byte_lo});

    always_comb
    begin
        result.frame_ok           = ok;
        result.function_code      = frame.func;
        result.calibrate_request  = ok && (frame.func == FUNC_CALIB) &&
                                    (frame.byte_hi == 8'd1 || frame.byte_hi == 8'd2);
        result.pid_report_request = ok && (frame.func == FUNC_PID) &&
                                    (frame.byte_hi == 8'd1);
        result.setpoint_write     = ok && (frame.func == FUNC_SETPOINT);
        result.save_timer_clear   = result.setpoint_write;
        result.ack_request        = ok && (frame.func >= FUNC_SETPOINT) &&
                                    (frame.func <= FUNC_ACK_LAST);
        result.ack_checksum       = frame.sum;
        if (!result.setpoint_write)
        begin
            result.setpoint_value = 16'sd0;
        end
        else if (raw > SETPOINT_MAX)
        begin
            result.setpoint_value = SETPOINT_MAX;
        end
        else
        begin
            result.setpoint_value = raw;
        end
    end

endmodule

FILE: sv/checksummed_command_frame_parser.sv
// ----------------------------------------------------------------------------
// checksummed_command_frame_parser
// Path: checksum byte passes the input register, then the result register, to out_valid.
// Throughput: one byte per cycle while not stalled; at most one transaction per frame out.
// Input stalls only while a result is held and out_stall is high.
// Reset (rst_n low, async): parser returns to header hunt, valid flags cleared.
// ----------------------------------------------------------------------------
module checksummed_command_frame_parser
    import cfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_ok,
    output logic [7:0]         function_code,
    output logic               calibrate_request,
    output logic               pid_report_request,
    output logic               setpoint_write,
    output logic signed [15:0] setpoint_value,
    output logic               ack_request,
    output logic [7:0]         ack_checksum,
    output logic               save_timer_clear
);

    logic       in_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       advance;
    logic       step;
    logic       done;
    frame_t     frame;
    result_t    result;
    logic       out_valid_reg;
    result_t    result_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            rx_byte_reg <= rx_byte;
        end
    end

    cfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte_reg),
        .done    (done),
        .frame   (frame)
    );

    cfp_decoder u_decoder (
        .frame  (frame),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            result_reg <= result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign frame_ok           = result_reg.frame_ok;
    assign function_code      = result_reg.function_code;
    assign calibrate_request  = result_reg.calibrate_request;
    assign pid_report_request = result_reg.pid_report_request;
    assign setpoint_write     = result_reg.setpoint_write;
    assign setpoint_value     = result_reg.setpoint_value;
    assign ack_request        = result_reg.ack_request;
    assign ack_checksum       = result_reg.ack_checksum;
    assign save_timer_clear   = result_reg.save_timer_clear;

    // A stalled input means a held result is blocking the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

    // A failed checksum must suppress every request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ok) |-> (!calibrate_request && !pid_report_request &&
            !setpoint_write && !ack_request && !save_timer_clear &&
            setpoint_value == 16'sd0))
    else $error("request raised on a bad frame");

    // Setpoint writes come with a save-timer clear and an acknowledge, clamped at SETPOINT_MAX
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && setpoint_write) |-> (save_timer_clear && ack_request &&
            setpoint_value <= SETPOINT_MAX))
    else $error("setpoint write decode mismatch");

    // A result is produced only from a byte that was in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid_reg))
    else $error("result without a consumed byte");

endmodule
